### rtl/glyph_to_dual_lcd_writes_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the glyph to dual LCD write sequencer
// Clocked on clk, disabled while rst_n is low.
// ------------------------------------------------------------------------
`ifndef GLYPH_TO_DUAL_LCD_WRITES_ASSERT_SVH
`define GLYPH_TO_DUAL_LCD_WRITES_ASSERT_SVH

// Same-cycle implication
`define GDLW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdlw assertion failed");

// Next-cycle implication
`define GDLW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdlw assertion failed");

`endif

### rtl/gdlw_pkg.sv
// ------------------------------------------------------------------------
// gdlw_pkg
// Types, codes and font contents for the glyph to dual LCD write sequencer.
// ------------------------------------------------------------------------
package gdlw_pkg;

  // Field widths
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_VIDEO = 2'd2;

  // Glyph and controller codes
  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'hFF;
  localparam logic [7:0]        PAGE_CMD     = 8'd184;
  localparam logic [7:0]        COL_CMD      = 8'h40;
  localparam int unsigned       GLYPH_COUNT  = 4;

  // Font store geometry
  localparam int unsigned ROM_BYTES   = 128;
  localparam int unsigned ROM_AW      = 7;
  localparam int unsigned GLYPH_BYTES = 32;
  localparam int unsigned ROM_GLYPHS  = ROM_BYTES / GLYPH_BYTES;
  localparam int unsigned BASE_W      = 2;

  // Write steps within one half: page, column, then 16 data bytes
  localparam int unsigned      STEP_W        = 5;
  localparam logic [STEP_W-1:0] STEP_PAGE     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_COLUMN   = 5'd1;
  localparam logic [STEP_W-1:0] STEP_DATA0    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_LAST     = 5'd17;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [7:0] FONT_ROM [ROM_BYTES] = '{
    8'h00,8'h20,8'h3F,8'hF0,8'h02,8'h00,8'h02,8'h00,
    8'h02,8'h00,8'h02,8'h08,8'h7F,8'hFC,8'h02,8'h80,
    8'h02,8'h80,8'h04,8'h80,8'h04,8'h80,8'h08,8'h80,
    8'h08,8'h82,8'h10,8'h82,8'h20,8'h7E,8'h40,8'h00,
    8'h08,8'h40,8'h08,8'h50,8'h10,8'h48,8'h10,8'h40,
    8'h22,8'h7C,8'h7F,8'hC0,8'h08,8'h44,8'h10,8'h7E,
    8'h23,8'hC0,8'h7C,8'h48,8'h00,8'h50,8'h00,8'h20,
    8'h1C,8'h60,8'hE0,8'h92,8'h43,8'h0A,8'h00,8'h06,
    8'h02,8'h00,8'h02,8'h00,8'h02,8'h10,8'h7F,8'hF8,
    8'h42,8'h10,8'h42,8'h10,8'h7F,8'hF0,8'h42,8'h10,
    8'h42,8'h10,8'h7F,8'hF0,8'h42,8'h10,8'h02,8'h00,
    8'h02,8'h04,8'h02,8'h04,8'h01,8'hFC,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

### rtl/glyph_to_dual_lcd_writes.sv
// ------------------------------------------------------------------------
// glyph_to_dual_lcd_writes
// Turns 16x16 glyph codes into page, column and data writes for a
// 128x64 panel built from two 64-column controllers.
// ------------------------------------------------------------------------
// A glyph request produces 36 controller writes, one per clock from a
// step sequencer while out_stall does not hold a write (two halves of a
// page command, a column command and 16 font bytes). After a glyph is
// taken, in_stall stays high while its writes are loaded, so no new glyph
// request is taken until they are all in the output register; a write
// that out_stall holds keeps in_stall high longer. The first write passes
// through the state register and then the output register. A newline
// request (code 255) produces no writes and is absorbed without going busy.
// The next request is taken as soon as the final write of the current glyph
// sits in the output register. The font is a fixed 128-byte table read in
// the same cycle as the step.
module glyph_to_dual_lcd_writes (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gdlw_pkg::CODE_W-1:0]   in_glyph_code,
  input  logic                          in_last_of_string,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_bus_byte,
  output logic                          out_is_data,
  output logic                          out_right_half,
  output logic                          out_last_write,
  // Configuration port
  input  logic                          cfg_we,
  input  logic [gdlw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdlw_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  import gdlw_pkg::*;

  // Configuration and string position
  logic [PAGE_W-1:0] start_page_r,   start_page_nxt;
  logic [COL_W-1:0]  start_column_r, start_column_nxt;
  logic              normal_video_r, normal_video_nxt;
  logic [PAGE_W-1:0] page_row_r,     page_row_nxt;
  logic [2:0]        glyph_count_r,  glyph_count_nxt;

  // Current glyph job
  state_t             state_r,  state_nxt;
  logic [PAGE_W-1:0]  page_r,   page_nxt;
  logic [COL_W-1:0]   col_r,    col_nxt;
  logic [BASE_W-1:0]  base_r,   base_nxt;
  logic               known_r,  known_nxt;
  logic               half_r,   half_nxt;
  logic [STEP_W-1:0]  step_r,   step_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         byte_r,  byte_nxt;
  logic               data_r,  data_nxt;
  logic               right_r, right_nxt;
  logic               last_r,  last_nxt;

  logic               accept;
  logic               load;
  logic [COL_W-1:0]   col_calc;
  logic [PAGE_W-1:0]  page_sel;
  logic [STEP_W-1:0]  data_off;
  logic [ROM_AW-1:0]  rom_addr;
  logic [7:0]         font_raw;
  logic [7:0]         wr_byte;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state_r == ST_RUN) && (!out_valid_r || !out_stall);

  // Column of the glyph about to start
  assign col_calc = start_column_r + {glyph_count_r, 4'b0000};

  // Shared write generator: one write per step
  assign page_sel = page_r + PAGE_W'(half_r);
  assign data_off = step_r - STEP_DATA0;
  assign rom_addr = {base_r, half_r, data_off[3:0]};
  assign font_raw = known_r ? FONT_ROM[rom_addr] : 8'h00;

  always_comb begin
    unique case (step_r)
      STEP_PAGE:   wr_byte = PAGE_CMD + {5'b00000, page_sel};
      STEP_COLUMN: wr_byte = COL_CMD | {2'b00, col_r[5:0]};
      default:     wr_byte = font_raw ^ {8{~normal_video_r}};
    endcase
  end

  // Sequencer, string position and output register
  always_comb begin
    start_page_nxt   = start_page_r;
    start_column_nxt = start_column_r;
    normal_video_nxt = normal_video_r;
    page_row_nxt     = page_row_r;
    glyph_count_nxt  = glyph_count_r;
    state_nxt        = state_r;
    page_nxt         = page_r;
    col_nxt          = col_r;
    base_nxt         = base_r;
    known_nxt        = known_r;
    half_nxt         = half_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r && out_stall;
    byte_nxt         = byte_r;
    data_nxt         = data_r;
    right_nxt        = right_r;
    last_nxt         = last_r;

    // Start a glyph or absorb a newline
    if (accept) begin
      if (in_glyph_code == NEWLINE_CODE) begin
        page_row_nxt    = page_row_r + PAGE_W'(2);
        glyph_count_nxt = 3'd0;
      end else begin
        state_nxt       = ST_RUN;
        page_nxt        = page_row_r;
        col_nxt         = col_calc;
        base_nxt        = in_glyph_code[BASE_W-1:0];
        known_nxt       = (32'(in_glyph_code) < GLYPH_COUNT) &&
                          (32'(in_glyph_code) < ROM_GLYPHS);
        half_nxt        = 1'b0;
        step_nxt        = STEP_PAGE;
        glyph_count_nxt = glyph_count_r + 3'd1;
      end
      if (in_last_of_string) begin
        page_row_nxt    = start_page_r;
        glyph_count_nxt = 3'd0;
      end
    end

    // Emit one write and advance the step counter
    if (load) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = wr_byte;
      data_nxt      = (step_r >= STEP_DATA0);
      right_nxt     = col_r[COL_W-1];
      last_nxt      = half_r && (step_r == STEP_LAST);
      if (step_r == STEP_LAST) begin
        step_nxt = STEP_PAGE;
        half_nxt = 1'b1;
        if (half_r) begin
          state_nxt = ST_IDLE;
        end
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end

    // Start page and start column writes restart the string
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_PAGE: begin
          start_page_nxt  = cfg_wdata[PAGE_W-1:0];
          page_row_nxt    = cfg_wdata[PAGE_W-1:0];
          glyph_count_nxt = 3'd0;
        end
        CFG_START_COLUMN: begin
          start_column_nxt = cfg_wdata;
          page_row_nxt     = start_page_r;
          glyph_count_nxt  = 3'd0;
        end
        CFG_NORMAL_VIDEO: begin
          normal_video_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_page_r   <= '0;
      start_column_r <= '0;
      normal_video_r <= 1'b1;
      page_row_r     <= '0;
      glyph_count_r  <= '0;
      state_r        <= ST_IDLE;
      half_r         <= 1'b0;
      step_r         <= STEP_PAGE;
      out_valid_r    <= 1'b0;
    end else begin
      start_page_r   <= start_page_nxt;
      start_column_r <= start_column_nxt;
      normal_video_r <= normal_video_nxt;
      page_row_r     <= page_row_nxt;
      glyph_count_r  <= glyph_count_nxt;
      state_r        <= state_nxt;
      half_r         <= half_nxt;
      step_r         <= step_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    col_r   <= col_nxt;
    base_r  <= base_nxt;
    known_r <= known_nxt;
    byte_r  <= byte_nxt;
    data_r  <= data_nxt;
    right_r <= right_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bus_byte   = byte_r;
  assign out_is_data    = data_r;
  assign out_right_half = right_r;
  assign out_last_write = last_r;

endmodule

### rtl/gdlw_chk.sv
// ------------------------------------------------------------------------
// gdlw_chk
// Port-level checks for the glyph to dual LCD write sequencer.
// ------------------------------------------------------------------------
`include "glyph_to_dual_lcd_writes_assert.svh"

module gdlw_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [gdlw_pkg::CODE_W-1:0]    in_glyph_code,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [7:0]                     out_bus_byte,
  input logic                           out_is_data,
  input logic                           out_last_write
);

  import gdlw_pkg::*;

  // Hold a stalled write
  `GDLW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus_byte) && $stable(out_is_data))

  // Close every glyph with a data write
  `GDLW_ASSERT_IMP(a_last_is_data, out_valid && out_last_write, out_is_data)

  // Command writes carry only page or column commands
  `GDLW_ASSERT_IMP(a_cmd_code, out_valid && !out_is_data, (out_bus_byte[7:3] == 5'b10111) || (out_bus_byte[7:6] == 2'b01))

  // Go busy after taking a glyph request
  `GDLW_ASSERT_NXT(a_busy_after_glyph, in_valid && !in_stall && (in_glyph_code != NEWLINE_CODE), in_stall)

endmodule

bind glyph_to_dual_lcd_writes gdlw_chk u_gdlw_chk (.*);
